@@ rtl/core/xsru_pkg.sv @@
// Shared types, constants and helpers for the xorshift64* random unit.
`default_nettype none
package xsru_pkg;

    localparam logic [63:0] SEED_XOR     = 64'h0000_0005_DEEC_E66D;
    localparam logic [63:0] SCRAMBLE_MUL = 64'h2545_F491_4F6C_DD1D;

    localparam int WORD_W = 64;
    localparam int NUM_W  = 33;

    localparam logic [2:0] FUNC_RAW   = 3'd0;
    localparam logic [2:0] FUNC_BOUND = 3'd1;
    localparam logic [2:0] FUNC_RANGE = 3'd2;
    localparam logic [2:0] FUNC_FRAC  = 3'd3;
    localparam logic [2:0] FUNC_BOOL  = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DSTART,
        S_DIV,
        S_OUT
    } t_state;

    // One xorshift64 step.
    function automatic logic [63:0] xs_advance(input logic [63:0] s_in);
        logic [63:0] s;
        s = s_in;
        s = s ^ (s >> 12);
        s = s ^ (s << 25);
        s = s ^ (s >> 27);
        return s;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/xsru_divider.sv @@
// Radix-2 restoring divider: remainder of a 64-bit word by a 33-bit divisor.
`default_nettype none
module xsru_divider
    import xsru_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [WORD_W-1:0]  i_dividend,
    input  wire logic [NUM_W-1:0]   i_divisor,
    output logic                    o_done,
    output logic [NUM_W-1:0]        o_rem
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [5:0]        r_cnt, n_cnt;
    logic [WORD_W-1:0] r_quo, n_quo;
    logic [NUM_W-1:0]  r_rem, n_rem;
    logic [NUM_W-1:0]  r_dsr, n_dsr;

    logic [NUM_W:0]    shifted;
    logic [NUM_W+1:0]  diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dsr <= n_dsr;
    end

    always_comb begin
        shifted = {r_rem, r_quo[WORD_W-1]};
        diff    = {1'b0, shifted} - {2'b00, r_dsr};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_dsr   = r_dsr;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            n_quo = {r_quo[WORD_W-2:0], 1'b0};
            // remainder stays below the divisor, so it fits NUM_W bits
            n_rem = diff[NUM_W+1] ? shifted[NUM_W-1:0] : diff[NUM_W-1:0];
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd63) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

@@ rtl/core/xorshift64_star_random_unit.sv @@
// Raw, fraction and boolean draws pass from the input beat through the S_MUL steps to the result.
// Bounded and range draws also pass through the shared radix-2 divider before the result.
// Draws that do not advance the state answer in the cycle after the input beat. One request at a time:
// the next input beat can come the cycle after the result beat.
// The 64x64 scramble is three passes through one shared 32x32 multiplier.
// Synchronous active-low reset: state = 0x5DEECE66D (seed 0), block idle.
`default_nettype none
module xorshift64_star_random_unit
    import xsru_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [63:0]        i_cfg_wdata,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [2:0]         i_func,
    input  wire logic [31:0]        i_lower,
    input  wire logic [32:0]        i_upper,
    input  wire logic [32:0]        i_probability,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [63:0]             o_random_word,
    output logic [32:0]             o_number,
    output logic                    o_hit,
    output logic                    o_advanced
);

    t_state            r_state, n_state;
    logic [63:0]       r_gen, n_gen;
    logic [2:0]        r_func, n_func;
    logic [31:0]       r_lower, n_lower;
    logic [NUM_W-1:0]  r_divisor, n_divisor;
    logic [32:0]       r_prob, n_prob;
    logic [63:0]       r_word, n_word;
    logic [63:0]       r_prod, n_prod;
    logic [1:0]        r_mcnt, n_mcnt;
    logic [NUM_W-1:0]  r_number, n_number;
    logic              r_hit, n_hit;
    logic              r_adv, n_adv;

    logic              in_beat;
    logic              range_empty;
    logic [NUM_W-1:0]  span;
    logic [31:0]       mul_a, mul_b;
    logic [63:0]       mul_p;
    logic [63:0]       word_fin;
    logic              div_start;
    logic              div_done;
    logic [NUM_W-1:0]  div_rem;

    xsru_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_word),
        .i_divisor  (r_divisor),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_gen   <= SEED_XOR;
            r_mcnt  <= '0;
        end else begin
            r_state <= n_state;
            r_gen   <= n_gen;
            r_mcnt  <= n_mcnt;
        end
        r_func    <= n_func;
        r_lower   <= n_lower;
        r_divisor <= n_divisor;
        r_prob    <= n_prob;
        r_word    <= n_word;
        r_prod    <= n_prod;
        r_number  <= n_number;
        r_hit     <= n_hit;
        r_adv     <= n_adv;
    end

    // low 64 bits of gen * MUL = aL*bL + ((aL*bH + aH*bL) << 32)
    always_comb begin
        case (r_mcnt)
            2'd1: begin
                mul_a = r_gen[31:0];
                mul_b = SCRAMBLE_MUL[63:32];
            end
            2'd2: begin
                mul_a = r_gen[63:32];
                mul_b = SCRAMBLE_MUL[31:0];
            end
            default: begin
                mul_a = r_gen[31:0];
                mul_b = SCRAMBLE_MUL[31:0];
            end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign word_fin = r_word + {r_prod[31:0], 32'd0};

    assign in_beat     = i_in_valid && o_in_ready;
    assign range_empty = $signed({i_lower[31], i_lower}) >= $signed(i_upper);
    // a non-empty span is below 2^33, so 33-bit wraparound gives it exactly
    assign span        = i_upper - {i_lower[31], i_lower} + 33'd1;

    always_comb begin
        n_state   = r_state;
        n_gen     = r_gen;
        n_func    = r_func;
        n_lower   = r_lower;
        n_divisor = r_divisor;
        n_prob    = r_prob;
        n_word    = r_word;
        n_prod    = r_prod;
        n_mcnt    = r_mcnt;
        n_number  = r_number;
        n_hit     = r_hit;
        n_adv     = r_adv;
        div_start = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_cfg_we) begin
                    n_gen = i_cfg_wdata ^ SEED_XOR;
                end
                if (in_beat) begin
                    n_func   = i_func;
                    n_lower  = i_lower;
                    n_prob   = i_probability;
                    n_word   = '0;
                    n_number = '0;
                    n_hit    = 1'b0;
                    n_adv    = 1'b0;
                    n_mcnt   = '0;
                    n_divisor = (i_func == FUNC_BOUND) ? {1'b0, i_upper[31:0]}
                                                       : span;
                    case (i_func)
                        FUNC_RAW, FUNC_FRAC, FUNC_BOOL: begin
                            n_gen   = xs_advance(r_gen);
                            n_adv   = 1'b1;
                            n_state = S_MUL;
                        end
                        FUNC_BOUND: begin
                            if (i_upper[31:0] == 32'd0) begin
                                n_state = S_OUT;
                            end else begin
                                n_gen   = xs_advance(r_gen);
                                n_adv   = 1'b1;
                                n_state = S_MUL;
                            end
                        end
                        FUNC_RANGE: begin
                            if (range_empty) begin
                                n_number = {i_lower[31], i_lower};
                                n_state  = S_OUT;
                            end else begin
                                n_gen   = xs_advance(r_gen);
                                n_adv   = 1'b1;
                                n_state = S_MUL;
                            end
                        end
                        default: begin
                            n_state = S_OUT;
                        end
                    endcase
                end
            end

            S_MUL: begin
                n_prod = mul_p;
                n_mcnt = r_mcnt + 2'd1;
                case (r_mcnt)
                    2'd0: ;
                    2'd1: n_word = r_word + r_prod;
                    2'd2: n_word = word_fin;
                    default: begin
                        n_word = word_fin;
                        if (r_func == FUNC_BOUND || r_func == FUNC_RANGE) begin
                            n_state = S_DSTART;
                        end else begin
                            if (r_func != FUNC_RAW) begin
                                n_number = {1'b0, word_fin[31:0]};
                            end
                            if (r_func == FUNC_BOOL) begin
                                n_hit = {1'b0, word_fin[31:0]} < r_prob;
                            end
                            n_state = S_OUT;
                        end
                    end
                endcase
            end

            S_DSTART: begin
                div_start = 1'b1;
                n_state   = S_DIV;
            end

            S_DIV: begin
                if (div_done) begin
                    // range result lo + rem always lands in [lower, upper]
                    n_number = (r_func == FUNC_BOUND) ? div_rem
                             : ({r_lower[31], r_lower} + div_rem);
                    n_state  = S_OUT;
                end
            end

            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = (r_state == S_OUT);
    assign o_random_word = r_word;
    assign o_number      = r_number;
    assign o_hit         = r_hit;
    assign o_advanced    = r_adv;

endmodule
`default_nettype wire
